// ===== hdl/limit_order_book_top_macros.svh =====
// Assertion macros used by the lob_checker module.
`ifndef LIMIT_ORDER_BOOK_TOP_MACROS_SVH
`define LIMIT_ORDER_BOOK_TOP_MACROS_SVH

// same-cycle implication
`define LOB_ASSERT_NOW(label, ant, con) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("lob check failed");

// next-cycle implication
`define LOB_ASSERT_NEXT(label, ant, con) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("lob check failed");

`endif

// ===== hdl/lob_pkg.sv =====
package lob_pkg;

  localparam int MAX_ORDERS = 64;
  localparam int IDX_W      = $clog2(MAX_ORDERS);
  localparam int PRICE_BITS = 32;
  localparam int QTY_BITS   = 32;
  localparam int ID_W       = 32;

  localparam logic [ID_W-1:0] ID_LAST = '1;

  localparam logic [1:0] REQ_PLACE  = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_QTY   = 2'd3;

  typedef struct packed {
    logic [1:0]            op;
    logic [ID_W-1:0]       id;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic                  side;
    logic [1:0]            kind;
  } cmd_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic                  side;
    logic [1:0]            kind;
  } view_t;

  // running best order handed down the cell row
  typedef struct packed {
    logic                  valid;
    logic [PRICE_BITS-1:0] price;
    logic [ID_W-1:0]       id;
    logic [QTY_BITS-1:0]   qty;
  } cand_t;

endpackage

// ===== hdl/lob_cell.sv =====
module lob_cell import lob_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            sel,
  input  cmd_t            cmd,
  input  logic [ID_W-1:0] match_id,
  input  cand_t           bid_in,
  input  cand_t           ask_in,
  output logic            occupied,
  output logic            hit,
  output view_t           view,
  output cand_t           bid_out,
  output cand_t           ask_out
);

  logic                  valid;
  logic [ID_W-1:0]       id;
  logic [PRICE_BITS-1:0] price;
  logic [QTY_BITS-1:0]   qty;
  logic                  side;
  logic [1:0]            kind;
  logic                  bid_take;
  logic                  ask_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel) begin
      case (cmd.op)
        OP_STORE: valid <= 1'b1;
        OP_CLEAR: valid <= 1'b0;
        default:  valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.op == OP_STORE) begin
      id    <= cmd.id;
      price <= cmd.price;
      qty   <= cmd.qty;
      side  <= cmd.side;
      kind  <= cmd.kind;
    end else if (sel && cmd.op == OP_QTY) begin
      qty <= cmd.qty;
    end
  end

  assign occupied = valid;
  assign hit      = valid && (id == match_id);
  assign view     = '{price: price, side: side, kind: kind};

  // earlier cells hold no priority by position; ties go to the lower id
  assign bid_take = valid && side == SIDE_BUY &&
                    (!bid_in.valid || price > bid_in.price ||
                     (price == bid_in.price && id < bid_in.id));
  assign ask_take = valid && side == SIDE_SELL &&
                    (!ask_in.valid || price < ask_in.price ||
                     (price == ask_in.price && id < ask_in.id));

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_out <= '0;
      ask_out <= '0;
    end else begin
      bid_out <= bid_take ? '{valid: 1'b1, price: price, id: id, qty: qty} : bid_in;
      ask_out <= ask_take ? '{valid: 1'b1, price: price, id: id, qty: qty} : ask_in;
    end
  end

endmodule

// ===== hdl/limit_order_book_top.sv =====
// Order book with price-time priority over 64 slots. A request is taken when start is high
// and busy is low; its one result appears on the result ports for a single cycle with
// done high, after the book is updated and the best bid / best ask search has run down
// the row of 64 slot cells one cell per cycle; busy falls the cycle after done.
// Results cannot be held off.
module limit_order_book_top import lob_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [31:0] order_ref,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  input  logic        side,
  input  logic [1:0]  order_kind,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] result_id,
  output logic        bid_valid,
  output logic [31:0] bid_price,
  output logic [31:0] bid_id,
  output logic [31:0] bid_quantity,
  output logic        ask_valid,
  output logic [31:0] ask_price,
  output logic [31:0] ask_id,
  output logic [31:0] ask_quantity
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state;
  logic [IDX_W-1:0]      cnt;
  logic [ID_W-1:0]       id_counter;
  logic [ID_W-1:0]       id_counter_next;
  logic [1:0]            r_type;
  logic [ID_W-1:0]       r_ref;
  logic [PRICE_BITS-1:0] r_price;
  logic [QTY_BITS-1:0]   r_qty;
  logic                  r_side;
  logic [1:0]            r_kind;
  logic [1:0]            st;
  logic [1:0]            st_next;
  logic [ID_W-1:0]       rid;
  logic [ID_W-1:0]       rid_next;

  logic [MAX_ORDERS-1:0] occ;
  logic [MAX_ORDERS-1:0] hits;
  logic [MAX_ORDERS-1:0] free_vec;
  logic [MAX_ORDERS-1:0] first_free;
  logic [MAX_ORDERS-1:0] sel;
  view_t                 views [MAX_ORDERS];
  view_t                 mview;
  cand_t                 bid_chain [MAX_ORDERS+1];
  cand_t                 ask_chain [MAX_ORDERS+1];
  cmd_t                  cmd;
  logic                  any_hit;
  logic                  any_free;

  assign bid_chain[0] = '0;
  assign ask_chain[0] = '0;

  for (genvar g = 0; g < MAX_ORDERS; g++) begin : g_cell
    lob_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .sel      (sel[g] && state == S_EXEC),
      .cmd      (cmd),
      .match_id (r_ref),
      .bid_in   (bid_chain[g]),
      .ask_in   (ask_chain[g]),
      .occupied (occ[g]),
      .hit      (hits[g]),
      .view     (views[g]),
      .bid_out  (bid_chain[g+1]),
      .ask_out  (ask_chain[g+1])
    );
  end

  assign free_vec   = ~occ;
  assign first_free = free_vec & (~free_vec + 1'b1);
  assign any_free   = |free_vec;
  assign any_hit    = |hits;

  // ids are unique, so at most one cell hits
  always_comb begin
    mview = '0;
    for (int i = 0; i < MAX_ORDERS; i++) begin
      if (hits[i]) mview = mview | views[i];
    end
  end

  always_comb begin
    cmd             = '{op: OP_NONE, id: id_counter + 1'b1, price: r_price, qty: r_qty,
                        side: r_side, kind: r_kind};
    sel             = hits;
    st_next         = ST_OK;
    rid_next        = r_ref;
    id_counter_next = id_counter;
    case (r_type)
      REQ_PLACE: begin
        sel      = first_free;
        rid_next = '0;
        if (!any_free || id_counter == ID_LAST) begin
          st_next = ST_FULL;
        end else begin
          cmd.op          = OP_STORE;
          rid_next        = id_counter + 1'b1;
          id_counter_next = id_counter + 1'b1;
        end
      end
      REQ_DELETE: begin
        if (!any_hit) st_next = ST_NOT_FOUND;
        else cmd.op = OP_CLEAR;
      end
      REQ_MODIFY: begin
        if (!any_hit) begin
          st_next = ST_NOT_FOUND;
        end else if (mview.price != r_price || mview.kind != r_kind) begin
          if (id_counter == ID_LAST) begin
            st_next = ST_FULL;
          end else begin
            cmd.op          = OP_STORE;
            cmd.side        = mview.side;
            rid_next        = id_counter + 1'b1;
            id_counter_next = id_counter + 1'b1;
          end
        end else begin
          cmd.op = OP_QTY;
        end
      end
      default: rid_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      id_counter <= '0;
    end else begin
      case (state)
        S_IDLE: if (start) state <= S_EXEC;
        S_EXEC: begin
          state      <= S_SWEEP;
          cnt        <= '0;
          id_counter <= id_counter_next;
        end
        S_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(MAX_ORDERS - 1)) state <= S_DONE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      r_type  <= req_type;
      r_ref   <= order_ref;
      r_price <= price;
      r_qty   <= quantity;
      r_side  <= side;
      r_kind  <= order_kind;
    end
    if (state == S_EXEC) begin
      st  <= st_next;
      rid <= rid_next;
    end
  end

  assign busy         = state != S_IDLE;
  assign done         = state == S_DONE;
  assign status       = st;
  assign result_id    = rid;
  assign bid_valid    = bid_chain[MAX_ORDERS].valid;
  assign bid_price    = bid_chain[MAX_ORDERS].price;
  assign bid_id       = bid_chain[MAX_ORDERS].id;
  assign bid_quantity = bid_chain[MAX_ORDERS].qty;
  assign ask_valid    = ask_chain[MAX_ORDERS].valid;
  assign ask_price    = ask_chain[MAX_ORDERS].price;
  assign ask_id       = ask_chain[MAX_ORDERS].id;
  assign ask_quantity = ask_chain[MAX_ORDERS].qty;

endmodule

// ===== hdl/lob_checker.sv =====
`include "limit_order_book_top_macros.svh"

module lob_checker import lob_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic        bid_valid,
  input logic [31:0] bid_price,
  input logic [31:0] bid_id,
  input logic        ask_valid,
  input logic [31:0] ask_id
);

  `LOB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `LOB_ASSERT_NOW(a_done_busy, done, busy)
  `LOB_ASSERT_NEXT(a_done_release, done, !busy && !done)
  `LOB_ASSERT_NOW(a_status_code, done, status == ST_OK || status == ST_NOT_FOUND || status == ST_FULL)
  `LOB_ASSERT_NOW(a_empty_sides, done, (bid_valid || (bid_price == 0 && bid_id == 0)) && (ask_valid || ask_id == 0))

endmodule

bind limit_order_book_top lob_checker u_lob_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .bid_valid (bid_valid),
  .bid_price (bid_price),
  .bid_id    (bid_id),
  .ask_valid (ask_valid),
  .ask_id    (ask_id)
);
